FILE: hdl/assert_macros.svh
// assertion helpers for the formatter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`endif

FILE: hdl/itf_pkg.sv
package itf_pkg;
    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_CHARS_DEF  = 64;
    localparam int CNT_W          = 7;
    localparam int DIG_W          = 4;

    localparam logic [2:0] RADIX_DEC     = 3'd0;
    localparam logic [2:0] RADIX_HEX_LO  = 3'd1;
    localparam logic [2:0] RADIX_HEX_UP  = 3'd2;
    localparam logic [2:0] RADIX_OCT     = 3'd3;
    localparam logic [2:0] RADIX_BIN_LO  = 3'd4;
    localparam logic [2:0] RADIX_BIN_UP  = 3'd5;

    localparam logic [2:0] SEC_LPAD = 3'd0;
    localparam logic [2:0] SEC_PFX  = 3'd1;
    localparam logic [2:0] SEC_ZERO = 3'd2;
    localparam logic [2:0] SEC_DIG  = 3'd3;
    localparam logic [2:0] SEC_TPAD = 3'd4;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_UP_B  = 8'h42;

    typedef struct packed {
        logic             push;
        logic             pop;
        logic [DIG_W-1:0] digit;
    } t_stack_ctrl;

    function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UP_A : CH_LO_A;
        if (d < 4'd10) return CH_ZERO + {4'd0, d};
        return base + {4'd0, d} - 8'd10;
    endfunction
endpackage

FILE: hdl/itf_div10.sv
module itf_div10 #(
    parameter int W = itf_pkg::VALUE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [W-1:0]            i_dividend,
    output logic [W-1:0]            o_quotient,
    output logic [itf_pkg::DIG_W-1:0] o_rem,
    output logic                    o_done
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]              r_q;
    logic [itf_pkg::DIG_W-1:0] r_rem;
    logic [CW-1:0]             r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [4:0]                n_t;
    logic                      n_qbit;
    logic [4:0]                n_r;

    always_comb begin
        n_t    = {r_rem, r_q[W-1]};
        n_qbit = (n_t >= 5'd10);
        n_r    = n_qbit ? n_t - 5'd10 : n_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_cnt  <= CW'(W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[W-2:0], n_qbit};
                r_rem <= n_r[3:0];
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient = r_q;
    assign o_rem      = r_rem;
    assign o_done     = r_done;
endmodule

FILE: hdl/itf_digit_stack.sv
module itf_digit_stack #(
    parameter int DEPTH = itf_pkg::VALUE_BITS_DEF
) (
    input  logic                      i_clk,
    input  itf_pkg::t_stack_ctrl      i_ctrl,
    output logic [itf_pkg::DIG_W-1:0] o_top
);
    logic [itf_pkg::DIG_W-1:0] r_stk [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_stk[0] <= i_ctrl.digit;
            for (int k = 1; k < DEPTH; k++) r_stk[k] <= r_stk[k-1];
        end else if (i_ctrl.pop) begin
            for (int k = 0; k < DEPTH - 1; k++) r_stk[k] <= r_stk[k+1];
        end
    end

    assign o_top = r_stk[0];
endmodule

FILE: hdl/integer_text_formatter_unit.sv
// integer text formatter: one integer with printf-style settings in, its ascii
// text out one character per output transaction, o_last_char on the final one.
// input channel i_valid / o_ready, output channel o_valid / i_ready.
// o_ready is high only while no value is being worked on; a transaction is
// taken in the cycle after the previous value's last character entered the
// output register, even if that character is still waiting to be taken.
// digit generation: a power-of-two radix gives one digit per cycle; decimal
// runs a bit-serial divide by ten for each digit. then a setup step, then
// one character per cycle from the output register while i_ready does not
// stall it, plus a bubble at each boundary between sections of the text
// (pad, prefix, zeros, digits, pad).
// a stall on i_ready freezes character output and the section counters.
// reset empties the output register and returns to idle; the digit stack
// needs no clearing since only freshly pushed digits are read.
module integer_text_formatter_unit #(
    parameter int VALUE_BITS = itf_pkg::VALUE_BITS_DEF,
    parameter int MAX_CHARS  = itf_pkg::MAX_CHARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_value,
    input  logic        i_is_signed,
    input  logic [2:0]  i_radix,
    input  logic        i_left_adjust,
    input  logic        i_force_plus,
    input  logic        i_space_sign,
    input  logic        i_alternate_form,
    input  logic        i_zero_pad,
    input  logic [6:0]  i_field_width,
    input  logic [5:0]  i_min_digits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_character,
    output logic        o_last_char
);
    `include "assert_macros.svh"

    localparam int W  = VALUE_BITS;
    localparam int CW = itf_pkg::CNT_W;

    typedef enum logic [2:0] {S_IDLE, S_GEN, S_DIV, S_CALC, S_EMIT} t_state;

    t_state          r_state;
    logic [W-1:0]    r_mag;
    logic [2:0]      r_shift;
    logic            r_upper;
    logic            r_left;
    logic            r_zero;
    logic [CW-1:0]   r_width;
    logic [CW-1:0]   r_prec;
    logic [7:0]      r_pfx [3];
    logic [1:0]      r_pre;
    logic [CW-1:0]   r_nd;
    logic [CW-1:0]   r_zer, r_tsp, r_count, r_emitted, r_rem;
    logic [2:0]      r_sec;
    logic            r_ov;
    logic [7:0]      r_char;
    logic            r_last;

    logic [W-1:0]    n_raw, n_mag, n_shmag;
    logic            n_neg;
    logic [7:0]      n_pfx [3];
    logic [1:0]      n_pre;
    logic [2:0]      n_shift;
    logic [CW-1:0]   n_p, n_len, n_w;
    logic [CW-1:0]   n_seclen;
    logic [3:0]      n_pdig;
    logic            n_step;
    logic            n_load;
    logic [7:0]      n_char;
    logic            div_start, div_done;
    logic [W-1:0]    div_q;
    logic [itf_pkg::DIG_W-1:0] div_rem, stk_top;
    itf_pkg::t_stack_ctrl stk_ctrl;

    always_comb begin
        n_raw = i_value[W-1:0];
        n_neg = i_is_signed && n_raw[W-1];
        n_mag = n_neg ? W'(0) - n_raw : n_raw;
        case (i_radix)
            itf_pkg::RADIX_HEX_LO, itf_pkg::RADIX_HEX_UP: n_shift = 3'd4;
            itf_pkg::RADIX_OCT:                           n_shift = 3'd3;
            itf_pkg::RADIX_BIN_LO, itf_pkg::RADIX_BIN_UP: n_shift = 3'd1;
            default:                                      n_shift = 3'd0;
        endcase
        n_pfx[0] = itf_pkg::CH_ZERO;
        n_pfx[1] = itf_pkg::CH_ZERO;
        n_pfx[2] = itf_pkg::CH_ZERO;
        n_pre    = 2'd0;
        if (n_neg) begin
            n_pfx[0] = itf_pkg::CH_MINUS;
            n_pre    = 2'd1;
        end else if (i_force_plus) begin
            n_pfx[0] = itf_pkg::CH_PLUS;
            n_pre    = 2'd1;
        end else if (i_space_sign) begin
            n_pfx[0] = itf_pkg::CH_SPACE;
            n_pre    = 2'd1;
        end
        if (i_alternate_form && n_shift != 3'd0) begin
            n_pfx[n_pre] = itf_pkg::CH_ZERO;
            n_pre        = n_pre + 2'd1;
            case (i_radix)
                itf_pkg::RADIX_HEX_LO: n_pfx[n_pre] = itf_pkg::CH_LO_X;
                itf_pkg::RADIX_HEX_UP: n_pfx[n_pre] = itf_pkg::CH_UP_X;
                itf_pkg::RADIX_BIN_LO: n_pfx[n_pre] = itf_pkg::CH_LO_B;
                itf_pkg::RADIX_BIN_UP: n_pfx[n_pre] = itf_pkg::CH_UP_B;
                default:               n_pfx[n_pre] = itf_pkg::CH_ZERO;
            endcase
            if (i_radix != itf_pkg::RADIX_OCT) n_pre = n_pre + 2'd1;
        end
    end

    always_comb begin
        case (r_shift)
            3'd4:    n_pdig = r_mag[3:0];
            3'd3:    n_pdig = {1'b0, r_mag[2:0]};
            default: n_pdig = {3'd0, r_mag[0]};
        endcase
        n_shmag = r_mag >> r_shift;
        n_p     = (r_prec > r_nd) ? r_prec : r_nd;
        n_len   = n_p + CW'(r_pre);
        n_w     = (r_width > n_len) ? r_width : n_len;
        case (r_sec)
            itf_pkg::SEC_LPAD: n_seclen = CW'(r_pre);
            itf_pkg::SEC_PFX:  n_seclen = r_zer;
            itf_pkg::SEC_ZERO: n_seclen = r_nd;
            default:           n_seclen = r_tsp;
        endcase
        n_step = (r_state == S_EMIT) && (!r_ov || i_ready);
        n_load = n_step && (r_rem != '0);
        case (r_sec)
            itf_pkg::SEC_PFX:  n_char = r_pfx[0];
            itf_pkg::SEC_ZERO: n_char = itf_pkg::CH_ZERO;
            itf_pkg::SEC_DIG:  n_char = itf_pkg::digit_char(stk_top, r_upper);
            default:           n_char = itf_pkg::CH_SPACE;
        endcase
    end

    assign div_start      = (r_state == S_GEN) && (r_shift == 3'd0);
    assign stk_ctrl.push  = ((r_state == S_GEN) && (r_shift != 3'd0)) ||
                            ((r_state == S_DIV) && div_done);
    assign stk_ctrl.pop   = n_load && (r_sec == itf_pkg::SEC_DIG);
    assign stk_ctrl.digit = (r_state == S_GEN) ? n_pdig : div_rem;

    itf_div10 #(.W(W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_mag),
        .o_quotient (div_q),
        .o_rem      (div_rem),
        .o_done     (div_done)
    );

    itf_digit_stack #(.DEPTH(W)) u_stack (
        .i_clk  (i_clk),
        .i_ctrl (stk_ctrl),
        .o_top  (stk_top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_nd    <= '0;
        end else begin
            if (i_ready && !n_load) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mag   <= n_mag;
                        r_shift <= n_shift;
                        r_upper <= (i_radix == itf_pkg::RADIX_HEX_UP);
                        r_left  <= i_left_adjust;
                        r_zero  <= i_zero_pad;
                        r_width <= (i_field_width > CW'(MAX_CHARS)) ?
                                   CW'(MAX_CHARS) : i_field_width;
                        r_prec  <= (i_min_digits > 6'(MAX_CHARS - 4)) ?
                                   CW'(MAX_CHARS - 4) : {1'b0, i_min_digits};
                        r_pfx   <= n_pfx;
                        r_pre   <= n_pre;
                        r_nd    <= '0;
                        r_state <= S_GEN;
                    end
                end
                S_GEN: begin
                    if (r_shift == 3'd0) begin
                        r_state <= S_DIV;
                    end else begin
                        r_mag   <= n_shmag;
                        r_nd    <= r_nd + CW'(1);
                        r_state <= (n_shmag == '0) ? S_CALC : S_GEN;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_mag   <= div_q;
                        r_nd    <= r_nd + CW'(1);
                        r_state <= (div_q == '0) ? S_CALC : S_GEN;
                    end
                end
                S_CALC: begin
                    r_zer     <= (r_zero && !r_left) ? n_w - CW'(r_pre) - r_nd : n_p - r_nd;
                    r_tsp     <= r_left ? n_w - n_len : '0;
                    r_rem     <= (!r_left && !r_zero) ? n_w - n_len : '0;
                    r_count   <= (n_w > CW'(MAX_CHARS)) ? CW'(MAX_CHARS) : n_w;
                    r_emitted <= '0;
                    r_sec     <= itf_pkg::SEC_LPAD;
                    r_state   <= S_EMIT;
                end
                S_EMIT: begin
                    if (n_step) begin
                        if (r_rem == '0) begin
                            r_sec <= r_sec + 3'd1;
                            r_rem <= n_seclen;
                        end else begin
                            r_ov      <= 1'b1;
                            r_char    <= n_char;
                            r_last    <= (r_emitted + CW'(1) == r_count);
                            r_rem     <= r_rem - CW'(1);
                            r_emitted <= r_emitted + CW'(1);
                            if (r_sec == itf_pkg::SEC_PFX) begin
                                r_pfx[0] <= r_pfx[1];
                                r_pfx[1] <= r_pfx[2];
                            end
                            if (r_emitted + CW'(1) == r_count) r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_ov;
    assign o_character = r_char;
    assign o_last_char = r_last;

    `ASSERT_CLK(a_emit_bound, i_clk, i_rst_n,
        (r_state == S_EMIT) |-> (r_emitted < r_count), "emitted past count")
    `ASSERT_CLK(a_nd_bound, i_clk, i_rst_n, (r_nd <= CW'(W)), "digit count overflow")
    `ASSERT_NEXT(a_accept_gen, i_clk, i_rst_n, i_valid && o_ready, r_state == S_GEN,
        "no digit phase after accept")
    `ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, n_load && (r_emitted + CW'(1) == r_count),
        o_last_char && o_ready, "last char without return to idle")
endmodule

FILE: test/itf_checker.sv
`timescale 1ns / 1ps
module itf_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [31:0] i_value,
    input  logic        i_is_signed,
    input  logic [2:0]  i_radix,
    input  logic        i_left_adjust,
    input  logic        i_force_plus,
    input  logic        i_space_sign,
    input  logic        i_alternate_form,
    input  logic        i_zero_pad,
    input  logic [6:0]  i_field_width,
    input  logic [5:0]  i_min_digits,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [7:0]  o_character,
    input  logic        o_last_char,
    output int          fail_count,
    output int          pending_chars
);
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char;

    t_char char_queue[$];
    int    mismatch_count;

    assign fail_count = mismatch_count;

    function automatic logic [7:0] radix_digit(input logic [3:0] d, input logic upper);
        if (d < 4'd10) return itf_pkg::CH_ZERO + {4'd0, d};
        return (upper ? itf_pkg::CH_UP_A : itf_pkg::CH_LO_A) + {4'd0, d} - 8'd10;
    endfunction

    task automatic format_value();
        logic [7:0]  prefix[4];
        logic [7:0]  digs[40];
        logic [7:0]  text[160];
        logic [31:0] mag;
        logic [2:0]  rdx;
        int          pre, nd, p, len, w, width, prec, shift, cnt, n;
        pre   = 0;
        nd    = 0;
        n     = 0;
        mag   = i_value;
        rdx   = (i_radix > itf_pkg::RADIX_BIN_UP) ? itf_pkg::RADIX_DEC : i_radix;
        width = (i_field_width > 64) ? 64 : i_field_width;
        prec  = (i_min_digits > 60) ? 60 : i_min_digits;
        if (i_is_signed && i_value[31]) begin
            prefix[pre++] = itf_pkg::CH_MINUS;
            mag = -i_value;
        end else if (i_force_plus) begin
            prefix[pre++] = itf_pkg::CH_PLUS;
        end else if (i_space_sign) begin
            prefix[pre++] = itf_pkg::CH_SPACE;
        end
        case (rdx)
            itf_pkg::RADIX_HEX_LO, itf_pkg::RADIX_HEX_UP: shift = 4;
            itf_pkg::RADIX_OCT: shift = 3;
            itf_pkg::RADIX_BIN_LO, itf_pkg::RADIX_BIN_UP: shift = 1;
            default: shift = 0;
        endcase
        if (i_alternate_form && rdx != itf_pkg::RADIX_DEC) begin
            prefix[pre++] = itf_pkg::CH_ZERO;
            if (rdx == itf_pkg::RADIX_HEX_LO) prefix[pre++] = itf_pkg::CH_LO_X;
            else if (rdx == itf_pkg::RADIX_HEX_UP) prefix[pre++] = itf_pkg::CH_UP_X;
            else if (rdx == itf_pkg::RADIX_BIN_LO) prefix[pre++] = itf_pkg::CH_LO_B;
            else if (rdx == itf_pkg::RADIX_BIN_UP) prefix[pre++] = itf_pkg::CH_UP_B;
        end
        do begin
            if (shift == 0) begin
                digs[nd++] = radix_digit(4'(mag % 10), 1'b0);
                mag = mag / 10;
            end else begin
                digs[nd++] = radix_digit(4'(mag & ((32'd1 << shift) - 1)),
                                         rdx == itf_pkg::RADIX_HEX_UP);
                mag = mag >> shift;
            end
        end while (mag != 0 && nd < 40);
        p   = (prec < nd) ? nd : prec;
        len = p + pre;
        w   = (width < len) ? len : width;
        if (!i_left_adjust && !i_zero_pad)
            for (int i = len; i < w; i++) text[n++] = itf_pkg::CH_SPACE;
        for (int i = 0; i < pre; i++) text[n++] = prefix[i];
        if (!i_left_adjust && i_zero_pad) begin
            for (int i = pre + nd; i < w; i++) text[n++] = itf_pkg::CH_ZERO;
        end else begin
            for (int i = nd; i < p; i++) text[n++] = itf_pkg::CH_ZERO;
        end
        for (int i = nd; i > 0; i--) text[n++] = digs[i-1];
        if (i_left_adjust)
            for (int i = len; i < w; i++) text[n++] = itf_pkg::CH_SPACE;
        cnt = (n < 64) ? n : 64;
        for (int i = 0; i < cnt; i++)
            char_queue = {char_queue, t_char'({text[i], (i + 1 == cnt)})};
    endtask

    always @(posedge i_clk) begin
        t_char exp_c;
        if (!i_rst_n) begin
            mismatch_count <= 0;
            pending_chars  <= 0;
        end else begin
            if (i_valid && o_ready) format_value();
            if (o_valid && i_ready) begin
                if (char_queue.size() == 0) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("unexpected character %h last %b", o_character, o_last_char);
                end else begin
                    exp_c = char_queue.pop_front();
                    if (exp_c.ch !== o_character || exp_c.last !== o_last_char) begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10)
                            $display("mismatch: expected %h/%b actual %h/%b",
                                     exp_c.ch, exp_c.last, o_character, o_last_char);
                    end
                end
            end
            pending_chars <= char_queue.size();
        end
    end
endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_value = '0;
    logic        i_is_signed = 1'b0;
    logic [2:0]  i_radix = itf_pkg::RADIX_DEC;
    logic        i_left_adjust = 1'b0;
    logic        i_force_plus = 1'b0;
    logic        i_space_sign = 1'b0;
    logic        i_alternate_form = 1'b0;
    logic        i_zero_pad = 1'b0;
    logic [6:0]  i_field_width = '0;
    logic [5:0]  i_min_digits = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_character;
    logic        o_last_char;
    int          fail_count;
    int          pending_chars;
    logic        calm = 1'b0;

    always #10 i_clk = ~i_clk;

    integer_text_formatter_unit u_top (.*);
    itf_checker u_chk (.*);

    always @(negedge i_clk) begin
        i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 12);
    end

    task automatic send(input logic [31:0] v, input logic s, input logic [2:0] r,
                        input logic [4:0] fl, input logic [6:0] fw, input logic [5:0] md);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 12) @(negedge i_clk);
        i_valid <= 1'b1;
        i_value <= v;
        i_is_signed <= s;
        i_radix <= r;
        {i_left_adjust, i_force_plus, i_space_sign, i_alternate_form, i_zero_pad} <= fl;
        i_field_width <= fw;
        i_min_digits <= md;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic send_random();
        logic [31:0] v;
        logic [6:0]  fw;
        logic [5:0]  md;
        case ($urandom_range(3))
            0: v = $urandom_range(20);
            1: v = -$urandom_range(20);
            default: v = $urandom;
        endcase
        fw = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(16));
        md = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(12));
        send(v, 1'($urandom), 3'($urandom), 5'($urandom), fw, md);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send(32'd0, 1'b0, itf_pkg::RADIX_DEC, 5'b00000, 7'd0, 6'd0);
        send(32'd0, 1'b0, itf_pkg::RADIX_OCT, 5'b00010, 7'd0, 6'd0);
        send(32'hffffffff, 1'b1, itf_pkg::RADIX_DEC, 5'b00000, 7'd0, 6'd0);
        send(32'h80000000, 1'b1, itf_pkg::RADIX_DEC, 5'b01000, 7'd12, 6'd0);
        send(32'hffffffff, 1'b0, itf_pkg::RADIX_DEC, 5'b01000, 7'd0, 6'd0);
        send(32'd42, 1'b0, itf_pkg::RADIX_DEC, 5'b00100, 7'd6, 6'd0);
        send(32'hdeadbeef, 1'b0, itf_pkg::RADIX_HEX_LO, 5'b00010, 7'd14, 6'd0);
        send(32'hdeadbeef, 1'b0, itf_pkg::RADIX_HEX_UP, 5'b00011, 7'd14, 6'd4);
        send(32'o777, 1'b0, itf_pkg::RADIX_OCT, 5'b00010, 7'd0, 6'd5);
        send(32'h5a, 1'b0, itf_pkg::RADIX_BIN_LO, 5'b00010, 7'd0, 6'd0);
        send(32'h5a, 1'b0, itf_pkg::RADIX_BIN_UP, 5'b10010, 7'd20, 6'd0);
        send(32'd7, 1'b0, 3'd6, 5'b00010, 7'd0, 6'd0);
        send(32'd7, 1'b0, 3'd7, 5'b00000, 7'd3, 6'd0);
        send(32'd123, 1'b0, itf_pkg::RADIX_DEC, 5'b10001, 7'd10, 6'd0);
        send(32'd123, 1'b0, itf_pkg::RADIX_DEC, 5'b00001, 7'd10, 6'd6);
        send(32'hfffffff0, 1'b1, itf_pkg::RADIX_HEX_LO, 5'b00001, 7'd10, 6'd0);
        send(32'd5, 1'b0, itf_pkg::RADIX_DEC, 5'b00000, 7'd127, 6'd0);
        send(32'd5, 1'b0, itf_pkg::RADIX_DEC, 5'b00000, 7'd0, 6'd63);
        send(32'hffffffff, 1'b0, itf_pkg::RADIX_BIN_LO, 5'b01110, 7'd64, 6'd63);
        send(32'd1, 1'b0, itf_pkg::RADIX_DEC, 5'b00000, 7'd64, 6'd60);
        while (pending_chars != 0) @(posedge i_clk);
        calm = 1'b1;
        for (int n = 0; n < 270; n++) begin
            if (n == 60) calm = 1'b0;
            if (n == 150) while (pending_chars != 0) @(posedge i_clk);
            send_random();
        end
        while (pending_chars != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending_chars == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
